// ===== hw/rtl/ssf_pkg.sv =====
// ----------------------------------------------------------------------------
// ssf_pkg - shared types, constants and tables of the smoothing factor unit
// Fixed-point formats, item structs and the log2 / exp2 interpolation tables.
// ----------------------------------------------------------------------------
package ssf_pkg;

  localparam int LOG_FRAC_BITS    = 16;
  localparam int TABLE_INDEX_BITS = 8;

  localparam int TAB_LEN   = (1 << TABLE_INDEX_BITS) + 1;
  localparam int LOG_SH    = 23 - TABLE_INDEX_BITS;
  localparam int LOG_ENT_W = LOG_FRAC_BITS + 1;
  localparam int EXP_ENT_W = 32;
  localparam int EXPO_W    = 9;
  localparam int LOG_W     = EXPO_W + LOG_FRAC_BITS + 1;
  localparam int EXP_SHIFT = LOG_FRAC_BITS - TABLE_INDEX_BITS;
  localparam int EXP_SH_POS = (EXP_SHIFT > 0) ? EXP_SHIFT : 0;
  localparam int EXP_R_W   = (EXP_SHIFT > 0) ? EXP_SHIFT : 1;
  localparam int Z_W       = LOG_FRAC_BITS + 6;
  localparam int N_W       = 6;
  localparam int ALPHA_W   = 17;
  localparam int P_W       = ALPHA_W + 1 + LOG_W;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd32768;

  localparam logic [31:0] FLT_ONE_BITS  = 32'h3F80_0000;
  localparam logic [31:0] FLT_LOW_BITS  = 32'h38D1_B717;
  localparam logic [31:0] FLT_HIGH_BITS = 32'h461C_4000;

  localparam logic [1:0] CASE_COMPUTED = 2'd0;
  localparam logic [1:0] CASE_NEUTRAL  = 2'd1;
  localparam logic [1:0] CASE_LOW      = 2'd2;
  localparam logic [1:0] CASE_HIGH     = 2'd3;

  typedef logic [LOG_ENT_W-1:0] log_tab_t [TAB_LEN];
  typedef logic [EXP_ENT_W-1:0] exp_tab_t [TAB_LEN];

  // one item handed from the front to the back
  typedef struct packed {
    logic                    neutral;
    logic signed [LOG_W-1:0] la;
    logic signed [LOG_W-1:0] lw;
  } front_item_t;

  function automatic longint unsigned isqrt64(input longint unsigned xin);
    longint unsigned x;
    longint unsigned r;
    longint unsigned b;
    x = xin;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2(1 + k/2^T) by repeated squaring
  function automatic log_tab_t build_log_tab();
    log_tab_t        t;
    longint unsigned y;
    longint unsigned acc;
    for (int k = 0; k < (1 << TABLE_INDEX_BITS); k++) begin
      y   = (64'd1 << 30) + (longint'(k) << (30 - TABLE_INDEX_BITS));
      acc = 0;
      for (int i = 0; i < LOG_FRAC_BITS + 2; i++) begin
        y   = (y * y) >> 30;
        acc = acc << 1;
        if (y >= (64'd2 << 30)) begin
          acc = acc | 64'd1;
          y   = y >> 1;
        end
      end
      t[k] = LOG_ENT_W'((acc + 64'd2) >> 2);
    end
    t[1 << TABLE_INDEX_BITS] = LOG_ENT_W'(64'd1 << LOG_FRAC_BITS);
    return t;
  endfunction

  // 2^(k/2^T) in Q2.30 from products of repeated square roots of two
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t        t;
    longint unsigned roots [TABLE_INDEX_BITS+1];
    longint unsigned p;
    roots[0] = 64'd2 << 30;
    for (int i = 1; i <= TABLE_INDEX_BITS; i++) roots[i] = isqrt64(roots[i-1] << 30);
    for (int k = 0; k < (1 << TABLE_INDEX_BITS); k++) begin
      p = 64'd1 << 30;
      for (int i = 1; i <= TABLE_INDEX_BITS; i++) begin
        if (((k >> (TABLE_INDEX_BITS - i)) & 1) != 0) p = (p * roots[i] + (64'd1 << 29)) >> 30;
      end
      t[k] = EXP_ENT_W'(p);
    end
    t[1 << TABLE_INDEX_BITS] = EXP_ENT_W'(64'd2 << 30);
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();
  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ===== hw/rtl/ssf_front.sv =====
// ----------------------------------------------------------------------------
// ssf_front - input decode and fixed-point log2 of both absmax values
// Four-stage pipeline: decode, table read, interpolation product, assembly.
// ----------------------------------------------------------------------------
module ssf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          act_bits,
  input  logic [31:0]          wgt_bits,
  output logic                 item_valid,
  input  logic                 item_ready,
  output ssf_pkg::front_item_t item
);

  typedef struct packed {
    logic                                   neutral;
    logic signed [ssf_pkg::EXPO_W-1:0]      e;
    logic [ssf_pkg::TABLE_INDEX_BITS-1:0]   k;
    logic [ssf_pkg::LOG_SH-1:0]             r;
  } dec_t;

  function automatic dec_t decode(input logic [31:0] x);
    dec_t        d;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [22:0] frac;
    logic [4:0]  lz;
    logic        found;
    ex      = x[30:23];
    man     = x[22:0];
    lz      = '0;
    found   = 1'b0;
    frac    = '0;
    d.neutral = x[31];
    d.e     = '0;
    if (ex == 8'hFF) begin
      if (man != '0) d.neutral = 1'b1;
      ex  = 8'hFE;
      man = '1;
    end
    if (ex == 8'h00) begin
      if (man == '0) begin
        d.neutral = 1'b1;
      end else begin
        for (int i = 22; i >= 0; i--) begin
          if (!found && man[i]) begin
            lz    = 5'(22 - i);
            found = 1'b1;
          end
        end
        frac = man << (lz + 5'd1);
        d.e  = -9'sd127 - $signed({4'b0, lz});
      end
    end else begin
      frac = man;
      d.e  = $signed({1'b0, ex}) - 9'sd127;
    end
    d.k = frac[22 -: ssf_pkg::TABLE_INDEX_BITS];
    d.r = frac[ssf_pkg::LOG_SH-1:0];
    return d;
  endfunction

  localparam int PR_W = ssf_pkg::LOG_ENT_W + ssf_pkg::LOG_SH;

  logic v1_r, v2_r, v3_r, v4_r;
  logic adv;

  dec_t da_r, dw_r;

  logic                                 n2_r;
  logic signed [ssf_pkg::EXPO_W-1:0]    ea2_r, ew2_r;
  logic [ssf_pkg::LOG_SH-1:0]           ra2_r, rw2_r;
  logic [ssf_pkg::LOG_ENT_W-1:0]        la0_2_r, lw0_2_r, dla2_r, dlw2_r;

  logic                                 n3_r;
  logic signed [ssf_pkg::EXPO_W-1:0]    ea3_r, ew3_r;
  logic [ssf_pkg::LOG_ENT_W-1:0]        la0_3_r, lw0_3_r;
  logic [PR_W-1:0]                      pa3_r, pw3_r;

  ssf_pkg::front_item_t item_r;

  logic [ssf_pkg::TABLE_INDEX_BITS:0]   ka0, kw0, ka1, kw1;
  logic [ssf_pkg::LOG_ENT_W-1:0]        lfa, lfw;

  assign adv      = !v4_r || item_ready;
  assign in_ready = adv;
  assign ka0      = {1'b0, da_r.k};
  assign kw0      = {1'b0, dw_r.k};
  assign ka1      = ka0 + 1'b1;
  assign kw1      = kw0 + 1'b1;

  always_comb begin
    lfa = la0_3_r + ssf_pkg::LOG_ENT_W'(pa3_r >> ssf_pkg::LOG_SH);
    lfw = lw0_3_r + ssf_pkg::LOG_ENT_W'(pw3_r >> ssf_pkg::LOG_SH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      da_r    <= decode(act_bits);
      dw_r    <= decode(wgt_bits);

      n2_r    <= da_r.neutral || dw_r.neutral;
      ea2_r   <= da_r.e;
      ew2_r   <= dw_r.e;
      ra2_r   <= da_r.r;
      rw2_r   <= dw_r.r;
      la0_2_r <= ssf_pkg::LOG_TAB[ka0];
      lw0_2_r <= ssf_pkg::LOG_TAB[kw0];
      dla2_r  <= ssf_pkg::LOG_TAB[ka1] - ssf_pkg::LOG_TAB[ka0];
      dlw2_r  <= ssf_pkg::LOG_TAB[kw1] - ssf_pkg::LOG_TAB[kw0];

      n3_r    <= n2_r;
      ea3_r   <= ea2_r;
      ew3_r   <= ew2_r;
      la0_3_r <= la0_2_r;
      lw0_3_r <= lw0_2_r;
      pa3_r   <= PR_W'(dla2_r) * PR_W'(ra2_r);
      pw3_r   <= PR_W'(dlw2_r) * PR_W'(rw2_r);

      item_r.neutral <= n3_r;
      item_r.la <= (ssf_pkg::LOG_W'(ea3_r) <<< ssf_pkg::LOG_FRAC_BITS)
                   + $signed(ssf_pkg::LOG_W'(lfa));
      item_r.lw <= (ssf_pkg::LOG_W'(ew3_r) <<< ssf_pkg::LOG_FRAC_BITS)
                   + $signed(ssf_pkg::LOG_W'(lfw));
    end
  end

  assign item_valid = v4_r;
  assign item       = item_r;

endmodule

// ===== hw/rtl/ssf_queue.sv =====
// ----------------------------------------------------------------------------
// ssf_queue - two-entry queue between front and back
// Lets either side stall without stopping the other at once.
// ----------------------------------------------------------------------------
module ssf_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  ssf_pkg::front_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output ssf_pkg::front_item_t pop_item
);

  ssf_pkg::front_item_t mem_r [2];
  logic                 wr_ptr_r, rd_ptr_r;
  logic [1:0]           count_r, count_nxt;
  logic                 push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

// ===== hw/rtl/ssf_back.sv =====
// ----------------------------------------------------------------------------
// ssf_back - log combine, exp2, float packing and clamp
// Six-stage pipeline ending in the output register.
// ----------------------------------------------------------------------------
module ssf_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ssf_pkg::ALPHA_W-1:0]   alpha_raw,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  ssf_pkg::front_item_t          item,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [31:0]                   res_scale,
  output logic [1:0]                    res_code
);

  localparam int F    = ssf_pkg::LOG_FRAC_BITS;
  localparam int T    = ssf_pkg::TABLE_INDEX_BITS;
  localparam int V_W  = ssf_pkg::P_W + 1;
  localparam int EP_W = ssf_pkg::EXP_ENT_W + ssf_pkg::EXP_R_W;
  localparam logic signed [V_W-1:0] Z_LIM = V_W'(16) <<< F;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic adv;

  logic n1_r, n2_r, n3_r, n4_r, n5_r;
  logic signed [ssf_pkg::P_W-1:0]     pa1_r, pw1_r;
  logic signed [ssf_pkg::Z_W-1:0]     z2_r;
  logic signed [ssf_pkg::N_W-1:0]     n3e_r, n4e_r, n5e_r;
  logic [T-1:0]                       k3_r;
  logic [ssf_pkg::EXP_R_W-1:0]        r3_r, r4_r;
  logic [ssf_pkg::EXP_ENT_W-1:0]      e0_4_r, de4_r, e0_5_r;
  logic [EP_W-1:0]                    p5_r;
  logic [31:0]                        scale_r;
  logic [1:0]                         code_r;

  logic [ssf_pkg::ALPHA_W-1:0]        alpha, beta;
  logic signed [V_W-1:0]              v, vr, zf, zc;
  logic [F-1:0]                       f;
  logic [F+T-1:0]                     fw;
  logic [T:0]                         k0, k1;
  logic [31:0]                        m, bits;
  logic [32:0]                        msum;
  logic [24:0]                        m24;
  logic [22:0]                        mant;
  logic signed [ssf_pkg::N_W+3:0]     nexp;
  logic [31:0]                        scale_nxt;
  logic [1:0]                         code_nxt;

  assign adv        = !v6_r || res_ready;
  assign item_ready = adv;

  always_comb begin
    alpha = (alpha_raw > ssf_pkg::ALPHA_ONE) ? ssf_pkg::ALPHA_ONE : alpha_raw;
    beta  = ssf_pkg::ALPHA_ONE - alpha;
    v     = V_W'(pa1_r) - V_W'(pw1_r);
    vr    = v + V_W'(32768);
    zf    = vr >>> 16;
    zc    = zf;
    if (zf > Z_LIM)  zc = Z_LIM;
    if (zf < -Z_LIM) zc = -Z_LIM;
    f     = z2_r[F-1:0];
    fw    = {f, T'(0)};
    k0    = {1'b0, k3_r};
    k1    = k0 + 1'b1;
  end

  always_comb begin
    m    = e0_5_r + 32'(p5_r >> ssf_pkg::EXP_SH_POS);
    msum = {1'b0, m} + 33'd64;
    m24  = msum[31:7];
    mant = m24[22:0];
    nexp = ssf_pkg::N_W'(n5e_r) + 10'sd127;
    if (m24[24]) begin
      mant = m24[23:1];
      nexp = nexp + 10'sd1;
    end
    bits = {1'b0, nexp[7:0], mant};
    scale_nxt = bits;
    code_nxt  = ssf_pkg::CASE_COMPUTED;
    if (n5_r) begin
      scale_nxt = ssf_pkg::FLT_ONE_BITS;
      code_nxt  = ssf_pkg::CASE_NEUTRAL;
    end else if (bits < ssf_pkg::FLT_LOW_BITS) begin
      scale_nxt = ssf_pkg::FLT_LOW_BITS;
      code_nxt  = ssf_pkg::CASE_LOW;
    end else if (bits > ssf_pkg::FLT_HIGH_BITS) begin
      scale_nxt = ssf_pkg::FLT_HIGH_BITS;
      code_nxt  = ssf_pkg::CASE_HIGH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= item_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n1_r  <= item.neutral;
      pa1_r <= ssf_pkg::P_W'($signed({1'b0, alpha})) * ssf_pkg::P_W'(item.la);
      pw1_r <= ssf_pkg::P_W'($signed({1'b0, beta}))  * ssf_pkg::P_W'(item.lw);

      n2_r  <= n1_r;
      z2_r  <= ssf_pkg::Z_W'(zc);

      n3_r  <= n2_r;
      n3e_r <= ssf_pkg::N_W'(z2_r >>> F);
      k3_r  <= fw[F+T-1:F];
      r3_r  <= ssf_pkg::EXP_R_W'(f & F'((1 << ssf_pkg::EXP_SH_POS) - 1));

      n4_r   <= n3_r;
      n4e_r  <= n3e_r;
      r4_r   <= r3_r;
      e0_4_r <= ssf_pkg::EXP_TAB[k0];
      de4_r  <= ssf_pkg::EXP_TAB[k1] - ssf_pkg::EXP_TAB[k0];

      n5_r   <= n4_r;
      n5e_r  <= n4e_r;
      e0_5_r <= e0_4_r;
      p5_r   <= EP_W'(de4_r) * EP_W'(r4_r);

      scale_r <= scale_nxt;
      code_r  <= code_nxt;
    end
  end

  assign res_valid = v6_r;
  assign res_scale = scale_r;
  assign res_code  = code_r;

endmodule

// ===== hw/rtl/smoothquant_scale_factor_unit.sv =====
// ----------------------------------------------------------------------------
// smoothquant_scale_factor_unit - SmoothQuant per-channel smoothing factor
// Returns a^alpha / w^(1-alpha), clamped to [1e-4, 1e4], as an IEEE single.
// ----------------------------------------------------------------------------
// channel   direction  payload
// in_*      slave      tdata[31:0] act_absmax, tdata[63:32] wgt_absmax
// out_*     master     tdata[31:0] scale, tuser[1:0] case_code
// cfg_*     slave      data[16:0] migration_strength
//
// One item per cycle sustained while out_tready stays high; a result passes
// through 4 front log2 stages, 1 queue entry, 5 back combine/exp2 stages
// and the output register. Zero, negative and NaN inputs give 1.0.
// The table interpolation multipliers set the stage count on each side.
// Reset is synchronous; migration_strength returns to 0.5.
// A stalled output holds the back; the two-entry queue then fills and
// in_tready falls.
// ----------------------------------------------------------------------------
module smoothquant_scale_factor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // act_absmax, wgt_absmax
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // scale
  output logic [1:0]  out_tuser,  // case_code
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data    // migration_strength
);

  logic [ssf_pkg::ALPHA_W-1:0] alpha_r;
  logic                        f_valid, f_ready, q_valid, q_ready;
  ssf_pkg::front_item_t        f_item, q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ssf_pkg::ALPHA_RESET;
    end else if (cfg_valid) begin
      alpha_r <= cfg_data;
    end
  end

  ssf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .act_bits   (in_tdata[31:0]),
    .wgt_bits   (in_tdata[63:32]),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  ssf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  ssf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .alpha_raw  (alpha_r),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_scale  (out_tdata),
    .res_code   (out_tuser)
  );

endmodule

// ===== bench/ssf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_checker - scoreboard for the smoothing factor unit
// Watches the input, result and register channels, predicts each factor in
// fixed point and compares it field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ssf_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [16:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] scale;
    logic [1:0]  code;
  } factor_t;

  factor_t     factor_q[$];
  logic [16:0] strength;
  longint      lg_tab [ssf_pkg::TAB_LEN];
  longint      ex_tab [ssf_pkg::TAB_LEN];

  assign pending = factor_q.size();

  initial begin
    for (int k = 0; k < ssf_pkg::TAB_LEN; k++) begin
      lg_tab[k] = longint'(ssf_pkg::LOG_TAB[k]);
      ex_tab[k] = longint'(ssf_pkg::EXP_TAB[k]);
    end
  end

  function automatic longint fl_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic bit log2_of(logic [31:0] x, output longint lv);
    logic [7:0]  ex;
    logic [23:0] man;
    int          e;
    longint      fr, k, r;
    ex  = x[30:23];
    man = {1'b0, x[22:0]};
    lv  = 0;
    if (x[31]) return 0;
    if (ex == 8'hFF) begin
      if (man != 0) return 0;
      ex  = 8'hFE;
      man = 24'h7FFFFF;
    end
    if (ex == 0) begin
      if (man == 0) return 0;
      e = -126;
      while (!man[23]) begin
        man = man << 1;
        e--;
      end
    end else begin
      man[23] = 1'b1;
      e = int'(ex) - 127;
    end
    fr = longint'(man) - 24'h800000;
    k  = fr >> ssf_pkg::LOG_SH;
    r  = fr & ((64'd1 << ssf_pkg::LOG_SH) - 1);
    lv = longint'(e) * (64'd1 << ssf_pkg::LOG_FRAC_BITS) + lg_tab[k]
       + fl_shr((lg_tab[k+1] - lg_tab[k]) * r, ssf_pkg::LOG_SH);
    return 1;
  endfunction

  function automatic factor_t predict_factor(logic [63:0] d);
    longint      la, lw, al, v, z, n, f, k, r, m, m24, lim;
    logic [31:0] b;
    factor_t     res;
    if (!log2_of(d[31:0], la) || !log2_of(d[63:32], lw)) begin
      res.scale = ssf_pkg::FLT_ONE_BITS;
      res.code  = ssf_pkg::CASE_NEUTRAL;
      return res;
    end
    al  = (strength > ssf_pkg::ALPHA_ONE) ? 65536 : longint'(strength);
    v   = al * la - (65536 - al) * lw;
    z   = fl_shr(v + 32768, 16);
    lim = 16 * (64'd1 << ssf_pkg::LOG_FRAC_BITS);
    if (z > lim) z = lim;
    if (z < -lim) z = -lim;
    n   = fl_shr(z, ssf_pkg::LOG_FRAC_BITS);
    f   = z - n * (64'd1 << ssf_pkg::LOG_FRAC_BITS);
    k   = f >> ssf_pkg::EXP_SHIFT;
    r   = f & ((64'd1 << ssf_pkg::EXP_SHIFT) - 1);
    m   = ex_tab[k] + fl_shr((ex_tab[k+1] - ex_tab[k]) * r, ssf_pkg::EXP_SHIFT);
    m24 = (m + 64) >> 7;
    if (m24 >= (64'd1 << 24)) begin
      m24 = m24 >> 1;
      n++;
    end
    b = {9'(n + 127), 23'(m24)};
    res.scale = b;
    res.code  = ssf_pkg::CASE_COMPUTED;
    if (b < ssf_pkg::FLT_LOW_BITS) begin
      res.scale = ssf_pkg::FLT_LOW_BITS;
      res.code  = ssf_pkg::CASE_LOW;
    end else if (b > ssf_pkg::FLT_HIGH_BITS) begin
      res.scale = ssf_pkg::FLT_HIGH_BITS;
      res.code  = ssf_pkg::CASE_HIGH;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    factor_t want;
    if (!rst_n) begin
      strength   <= ssf_pkg::ALPHA_RESET;
      fail_count <= 0;
      factor_q.delete();
    end else begin
      if (in_tvalid && in_tready) factor_q.push_back(predict_factor(in_tdata));
      if (cfg_valid && cfg_ready) strength <= cfg_data;
      if (out_tvalid && out_tready) begin
        if (factor_q.size() == 0) begin
          $display("%0t: unexpected result scale %h code %0d", $time, out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = factor_q.pop_front();
          if (want.scale !== out_tdata || want.code !== out_tuser) begin
            $display("%0t: expected scale %h code %0d, got scale %h code %0d",
                     $time, want.scale, want.code, out_tdata, out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - stimulus and verdict for the smoothing factor unit
// Directed corner values, then random channel pairs over several strength
// settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [16:0] cfg_data;
  int          fail_count;
  int          pending;
  int          idle_cycles;

  smoothquant_scale_factor_unit dut (.*);

  ssf_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_float();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return {1'b0, 8'($urandom_range(100, 154)), 23'($urandom)};
    if (p < 70) return {1'b0, 8'd0, 23'($urandom)};
    if (p < 75) return {1'b0, 8'hFF, 23'($urandom_range(0, 1) ? $urandom : 0)};
    if (p < 80) return 32'd0;
    if (p < 85) return {1'b1, 31'($urandom)};
    return $urandom;
  endfunction

  // hold tvalid across back-to-back items; drop it only for a gap
  task automatic send_item(logic [31:0] a, logic [31:0] w);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {w, a};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  task automatic write_strength(logic [16:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // result side: random back-pressure
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      out_tready <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [16:0] settings [6];
    logic [31:0] corner [10];
    settings = '{17'd0, 17'd65536, 17'd131071, 17'd16384, 17'd52000, 17'd32768};
    corner = '{32'h3F800000, 32'h7F7FFFFF, 32'h7F800000, 32'h00000001,
               32'h007FFFFF, 32'h00000000, 32'h80000000, 32'h7FC00000,
               32'hFF800000, 32'h3F7FFFFF};
    rst_n = 0; in_tvalid = 0; in_tdata = 0; cfg_valid = 0; cfg_data = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: corners against one and against each other under reset alpha
    for (int i = 0; i < 10; i++) send_item(corner[i], 32'h3F800000);
    for (int i = 0; i < 10; i++) send_item(32'h3F800000, corner[i]);
    send_item(32'h7F7FFFFF, 32'h00000001);
    send_item(32'h00000001, 32'h7F7FFFFF);
    send_item(32'hFFFFFFFF, 32'hFFFFFFFF);
    for (int s = 0; s < 6; s++) begin
      write_strength(settings[s]);
      send_item(32'h7F7FFFFF, 32'h00000001);
      send_item(32'h00000001, 32'h7F7FFFFF);
      for (int i = 0; i < 145; i++) begin
        if (i == 70) drain();
        send_item(rand_float(), rand_float());
      end
    end
    write_strength(17'($urandom));
    for (int i = 0; i < 30; i++) send_item($urandom, $urandom);
    drain();
    if (fail_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
